[design/arm_pose_collision_check_core_assert.svh]
// ----------------------------------------------------------------------------
// arm pose collision check assertion macros
// concurrent checks on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ARM_POSE_COLLISION_CHECK_CORE_ASSERT_SVH
`define ARM_POSE_COLLISION_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define APCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define APCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APCC_ASSERT_IMP(lbl, ante, cons, msg)
`define APCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[design/apcc_pkg.sv]
// ----------------------------------------------------------------------------
// apcc_pkg
// shared types, constants and helpers of the arm pose collision checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apcc_pkg;

	// field widths
	localparam int COORD_W    = 16;
	localparam int RAD_W      = 15;
	localparam int SLOT_W     = 3;
	localparam int CAUSE_W    = 3;
	localparam int OCNT_W     = 4;
	localparam int SRAD_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_RADIUS    = 2'd2;

	// register reset values
	localparam logic signed [COORD_W-1:0] HEIGHT_LIMIT_RST = -16'sd819;
	localparam logic [SRAD_W-1:0]         SELF_RADIUS_RST  = 14'd164;

	// verdict causes
	localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_TABLE   = 3'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_POINT   = 3'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_SEGMENT = 3'd3;
	localparam logic [CAUSE_W-1:0] CAUSE_SELF    = 3'd4;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	// link spheres: centres at thirds, pairs at least five apart
	localparam int SPHERES_PER_LINK = 3;
	localparam int SPHERE_SLOTS     = SPHERES_PER_LINK + 1;
	localparam int SELF_GAP         = 5;

	// datapath widths
	localparam int OPND_W = 19;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = 41;
	localparam int SER_W  = 37;
	localparam int SER_CW = 6;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_POINT,
		KIND_DROP
	} item_kind_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t             c;
		logic [RAD_W-1:0] r;
	} obst_t;

	typedef struct packed {
		item_kind_t        kind;
		logic              last;
		logic [SLOT_W-1:0] slot;
		vec_t              pos;
		logic [RAD_W-1:0]  radius;
	} queue_item_t;

	typedef struct packed {
		logic [OCNT_W-1:0]         obstacle_count;
		logic signed [COORD_W-1:0] height_limit;
		logic [SRAD_W-1:0]         self_radius;
	} cfg_regs_t;

	// one coordinate of a vector
	function automatic logic signed [COORD_W-1:0] vec_axis(input vec_t v, input logic [1:0] k);
		logic signed [COORD_W-1:0] r;
		case (k)
			2'd0:    r = v.x;
			2'd1:    r = v.y;
			default: r = v.z;
		endcase
		return r;
	endfunction

	// sphere centre scaled by three: a*(3-s) + b*s
	function automatic logic signed [OPND_W-1:0] centre_axis(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic [1:0]                s
	);
		logic signed [OPND_W-1:0] ea;
		logic signed [OPND_W-1:0] eb;
		logic signed [OPND_W-1:0] r;
		ea = OPND_W'(a);
		eb = OPND_W'(b);
		case (s)
			2'd0:    r = (ea <<< 1) + ea;
			2'd1:    r = (ea <<< 1) + eb;
			2'd2:    r = ea + (eb <<< 1);
			default: r = (eb <<< 1) + eb;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[design/apcc_front.sv]
// ----------------------------------------------------------------------------
// apcc_front
// takes items, classifies them into queue entries, holds the registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apcc_front #(
	parameter int MAX_OBSTACLES = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           command,
	input  wire logic [apcc_pkg::SLOT_W-1:0]    slot,
	input  wire logic signed [15:0]             pos_x,
	input  wire logic signed [15:0]             pos_y,
	input  wire logic signed [15:0]             pos_z,
	input  wire logic [apcc_pkg::RAD_W-1:0]     radius,
	input  wire logic                           last,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [apcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [apcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           q_full,
	output logic                                q_push,
	output apcc_pkg::queue_item_t               q_item,
	output apcc_pkg::cfg_regs_t                 cfg
);
	import apcc_pkg::*;

	cfg_regs_t cfg_q;

	// accept whenever the queue has room
	assign busy      = q_full;
	assign q_push    = start && !q_full;
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// classify the item
	always_comb begin
		q_item.last   = last;
		q_item.slot   = slot;
		q_item.pos.x  = pos_x;
		q_item.pos.y  = pos_y;
		q_item.pos.z  = pos_z;
		q_item.radius = radius;
		if (command == CMD_POINT) begin
			q_item.kind = KIND_POINT;
		end else if (32'(slot) >= MAX_OBSTACLES) begin
			q_item.kind = KIND_DROP;
		end else begin
			q_item.kind = KIND_LOAD;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_count <= '0;
			cfg_q.height_limit   <= HEIGHT_LIMIT_RST;
			cfg_q.self_radius    <= SELF_RADIUS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OBSTACLE_COUNT: cfg_q.obstacle_count <= cfg_data[OCNT_W-1:0];
				CFG_HEIGHT_LIMIT:   cfg_q.height_limit   <= cfg_data;
				CFG_SELF_RADIUS:    cfg_q.self_radius    <= cfg_data[SRAD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/apcc_queue.sv]
// ----------------------------------------------------------------------------
// apcc_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arm_pose_collision_check_core_assert.svh"

module apcc_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire apcc_pkg::queue_item_t item_in,
	output logic                       full,
	input  wire logic                  pop,
	output apcc_pkg::queue_item_t      item_out,
	output logic                       empty
);
	import apcc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	queue_item_t      slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (32'(cnt_q) == QUEUE_DEPTH);
	assign empty    = (cnt_q == '0);
	assign item_out = slots_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= item_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (32'(wptr_q) == QUEUE_DEPTH - 1) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (32'(rptr_q) == QUEUE_DEPTH - 1) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`APCC_ASSERT_IMP(a_no_overflow, push, !full, "apcc_queue: push into full queue")
	`APCC_ASSERT_IMP(a_no_underflow, pop, !empty, "apcc_queue: pop from empty queue")
	`APCC_ASSERT_NXT(a_push_fills, push && !pop, !empty, "apcc_queue: pushed item lost")

endmodule

`default_nettype wire

[design/apcc_back.sv]
// ----------------------------------------------------------------------------
// apcc_back
// stores obstacles and points, tests them on shared and serial multipliers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arm_pose_collision_check_core_assert.svh"

module apcc_back #(
	parameter int MAX_OBSTACLES = 8,
	parameter int MAX_POINTS    = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire apcc_pkg::cfg_regs_t     cfg,
	input  wire logic                    empty,
	input  wire apcc_pkg::queue_item_t   item,
	output logic                         pop,
	output logic                         done,
	output logic                         collision,
	output logic [apcc_pkg::CAUSE_W-1:0] cause
);
	import apcc_pkg::*;

	localparam int OBS_AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int NOB_W   = $clog2(MAX_OBSTACLES + 1);
	localparam int PT_AW   = $clog2(MAX_POINTS);
	localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CTR_W   = $clog2(MAX_POINTS * SPHERE_SLOTS + SELF_GAP);
	localparam int PT_PRODS   = 4;
	localparam int SEG_PRODS  = 10;
	localparam int SELF_PRODS = 4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TABLE,
		ST_PT_FETCH,
		ST_PT_MUL,
		ST_PT_CHK,
		ST_SEG_INIT,
		ST_SEG_FETCH,
		ST_SEG_MUL,
		ST_SEG_CHK,
		ST_SER,
		ST_SER_CHK,
		ST_SEG_NEXT,
		ST_SELF_INIT,
		ST_SELF_FETCH,
		ST_SELF_MUL,
		ST_SELF_CHK
	} state_t;

	state_t state_q;
	logic   fin_q;

	// storage
	vec_t  pbuf [MAX_POINTS];
	obst_t otab [MAX_OBSTACLES];
	vec_t  prd_q;
	obst_t ord_q;

	// pose bookkeeping and loop counters
	logic [PCNT_W-1:0]         pcnt_q;
	logic signed [COORD_W-1:0] last_z_q;
	logic [PCNT_W-1:0]         pi_q;
	logic [NOB_W-1:0]          oj_q;
	logic [CTR_W-1:0]          ci_q;
	logic [CTR_W-1:0]          cj_q;
	logic [CTR_W-1:0]          total_q;
	logic [2:0]                fcnt_q;
	logic [3:0]                mcnt_q;
	logic [CAUSE_W-1:0]        res_q;

	// operands
	vec_t  pa_q, pb_q, pc_q, pd_q;
	obst_t ob_q;

	// multiplier pipe and accumulators
	logic signed [PROD_W-1:0] prod_q;
	logic [1:0]               pdst_q;
	logic                     pv_q;
	logic signed [ACC_W-1:0]  acc_q [4];

	// serial multiplier for the vertex test
	logic [2*SER_W-1:0] ser_mc_q;
	logic [SER_W-1:0]   ser_ml_q;
	logic [2*SER_W-1:0] ser_acc_q;
	logic [2*SER_W-1:0] ser_lhs_q;
	logic [SER_W-1:0]   ser_nb_q;
	logic [SER_CW-1:0]  ser_cnt_q;
	logic               ser_ph_q;

	logic                     done_q;
	logic                     collision_q;
	logic [CAUSE_W-1:0]       cause_q;

	// combinational helpers
	logic [NOB_W-1:0]         nob;
	logic [CTR_W-1:0]         total_nx;
	logic [PCNT_W-1:0]        pi_nx;
	logic [CTR_W-1:0]         ci_nx;
	logic [PT_AW-1:0]         pra;
	logic [OBS_AW-1:0]        ora;
	logic                     pwe;
	logic                     owe;
	logic [2:0]               nreads;
	logic [3:0]               nprods;
	logic [1:0]               ax;
	logic signed [OPND_W-1:0] dif_pt, v_seg, w_seg, d_self, rad_op, lim_op;
	logic signed [OPND_W-1:0] op_a, op_b;
	logic [1:0]               op_dst;
	logic                     issue;
	logic signed [ACC_W-1:0]  c_seg;
	logic signed [ACC_W-1:0]  end_seg;
	logic [2*SER_W-1:0]       ser_sum;

	assign done      = done_q;
	assign collision = collision_q;
	assign cause     = cause_q;

	// obstacle count clamped to the table
	assign nob = (32'(cfg.obstacle_count) > MAX_OBSTACLES) ? NOB_W'(MAX_OBSTACLES)
		: NOB_W'(cfg.obstacle_count);
	assign total_nx = CTR_W'({pcnt_q - 1'b1, 2'b00});
	assign pi_nx    = pi_q + 1'b1;
	assign ci_nx    = ci_q + 1'b1;

	// queue pop and storage writes
	assign pop = (state_q == ST_IDLE) && !fin_q && !empty;
	assign pwe = pop && (item.kind == KIND_POINT) && (32'(pcnt_q) < MAX_POINTS);
	assign owe = pop && (item.kind == KIND_LOAD);

	// read addresses per fetch step
	always_comb begin
		pra = pi_q[PT_AW-1:0];
		ora = oj_q[OBS_AW-1:0];
		nreads = 3'd1;
		unique case (state_q)
			ST_SEG_FETCH: begin
				nreads = 3'd2;
				if (fcnt_q == 3'd1) begin
					pra = pi_nx[PT_AW-1:0];
				end
			end
			ST_SELF_FETCH: begin
				nreads = 3'd4;
				unique case (fcnt_q)
					3'd0:    pra = ci_q[PT_AW+1:2];
					3'd1:    pra = ci_q[PT_AW+1:2] + 1'b1;
					3'd2:    pra = cj_q[PT_AW+1:2];
					default: pra = cj_q[PT_AW+1:2] + 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	// point and obstacle memories
	always_ff @(posedge clk) begin
		if (pwe) begin
			pbuf[pcnt_q[PT_AW-1:0]] <= item.pos;
		end
		prd_q <= pbuf[pra];
	end

	always_ff @(posedge clk) begin
		if (owe) begin
			otab[OBS_AW'(item.slot)] <= {item.pos, item.radius};
		end
		ord_q <= otab[ora];
	end

	// axis of the current product
	always_comb begin
		ax = mcnt_q[1:0];
		if (state_q == ST_SEG_MUL) begin
			if (mcnt_q >= 4'd6) begin
				ax = 2'(mcnt_q - 4'd6);
			end else if (mcnt_q >= 4'd3) begin
				ax = 2'(mcnt_q - 4'd3);
			end
		end
	end

	// operand differences on the chosen axis
	assign dif_pt = OPND_W'(vec_axis(pa_q, ax)) - OPND_W'(vec_axis(ob_q.c, ax));
	assign w_seg  = dif_pt;
	assign v_seg  = OPND_W'(vec_axis(pb_q, ax)) - OPND_W'(vec_axis(pa_q, ax));
	assign d_self = centre_axis(vec_axis(pa_q, ax), vec_axis(pb_q, ax), ci_q[1:0])
		- centre_axis(vec_axis(pc_q, ax), vec_axis(pd_q, ax), cj_q[1:0]);
	assign rad_op = OPND_W'(ob_q.r);
	assign lim_op = OPND_W'({cfg.self_radius, 2'b00}) + OPND_W'({cfg.self_radius, 1'b0});

	// product schedule
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_dst = 2'd0;
		nprods = 4'd0;
		unique case (state_q)
			ST_PT_MUL: begin
				nprods = 4'(PT_PRODS);
				if (mcnt_q < 4'd3) begin
					op_a = dif_pt;
					op_b = dif_pt;
				end else begin
					op_a   = rad_op;
					op_b   = rad_op;
					op_dst = 2'd1;
				end
			end
			ST_SEG_MUL: begin
				nprods = 4'(SEG_PRODS);
				if (mcnt_q < 4'd3) begin
					op_a = v_seg;
					op_b = v_seg;
				end else if (mcnt_q < 4'd6) begin
					op_a   = v_seg;
					op_b   = w_seg;
					op_dst = 2'd1;
				end else if (mcnt_q < 4'd9) begin
					op_a   = w_seg;
					op_b   = w_seg;
					op_dst = 2'd2;
				end else begin
					op_a   = rad_op;
					op_b   = rad_op;
					op_dst = 2'd3;
				end
			end
			ST_SELF_MUL: begin
				nprods = 4'(SELF_PRODS);
				if (mcnt_q < 4'd3) begin
					op_a = d_self;
					op_b = d_self;
				end else begin
					op_a   = lim_op;
					op_b   = lim_op;
					op_dst = 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign issue = ((state_q == ST_PT_MUL) || (state_q == ST_SEG_MUL) ||
		(state_q == ST_SELF_MUL)) && (mcnt_q < nprods);

	// segment end value and shift-add step
	assign c_seg   = acc_q[2] - acc_q[3];
	assign end_seg = acc_q[0] + (acc_q[1] <<< 1) + c_seg;
	assign ser_sum = ser_acc_q + (ser_ml_q[0] ? ser_mc_q : '0);

	// verdict sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			pcnt_q      <= '0;
			pi_q        <= '0;
			oj_q        <= '0;
			ci_q        <= '0;
			cj_q        <= '0;
			total_q     <= '0;
			fcnt_q      <= '0;
			mcnt_q      <= '0;
			res_q       <= CAUSE_NONE;
			pv_q        <= 1'b0;
			pdst_q      <= '0;
			ser_cnt_q   <= '0;
			ser_ph_q    <= 1'b0;
			done_q      <= 1'b0;
			collision_q <= 1'b0;
			cause_q     <= CAUSE_NONE;
		end else begin
			done_q <= 1'b0;

			// multiplier pipe
			pv_q <= issue;
			if (issue) begin
				prod_q <= op_a * op_b;
				pdst_q <= op_dst;
			end
			if (pv_q) begin
				acc_q[pdst_q] <= acc_q[pdst_q] + ACC_W'(prod_q);
			end

			// operand capture from the registered reads
			if ((state_q == ST_PT_FETCH) || (state_q == ST_SEG_FETCH) ||
				(state_q == ST_SELF_FETCH)) begin
				unique case (fcnt_q)
					3'd1: begin
						pa_q <= prd_q;
						ob_q <= ord_q;
					end
					3'd2:    pb_q <= prd_q;
					3'd3:    pc_q <= prd_q;
					3'd4:    pd_q <= prd_q;
					default: ;
				endcase
				if (fcnt_q == nreads) begin
					mcnt_q <= '0;
					for (int k = 0; k < 4; k++) begin
						acc_q[k] <= '0;
					end
				end
			end

			if (fin_q) begin
				// deliver the verdict
				fin_q       <= 1'b0;
				done_q      <= 1'b1;
				cause_q     <= res_q;
				collision_q <= (res_q != CAUSE_NONE);
				pcnt_q      <= '0;
				state_q     <= ST_IDLE;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (pop && (item.kind == KIND_POINT)) begin
							if (32'(pcnt_q) < MAX_POINTS) begin
								pcnt_q   <= pcnt_q + 1'b1;
								last_z_q <= item.pos.z;
							end
							if (item.last) begin
								state_q <= ST_TABLE;
							end
						end
					end
					ST_TABLE: begin
						pi_q   <= '0;
						oj_q   <= '0;
						fcnt_q <= '0;
						if (last_z_q < cfg.height_limit) begin
							res_q <= CAUSE_TABLE;
							fin_q <= 1'b1;
						end else if (nob != '0) begin
							state_q <= ST_PT_FETCH;
						end else begin
							state_q <= ST_SEG_INIT;
						end
					end
					ST_PT_FETCH: begin
						if (fcnt_q == nreads) begin
							state_q <= ST_PT_MUL;
						end else begin
							fcnt_q <= fcnt_q + 1'b1;
						end
					end
					ST_PT_MUL: begin
						if (mcnt_q == nprods) begin
							state_q <= ST_PT_CHK;
						end else begin
							mcnt_q <= mcnt_q + 1'b1;
						end
					end
					ST_PT_CHK: begin
						fcnt_q <= '0;
						if (acc_q[0] < acc_q[1]) begin
							res_q <= CAUSE_POINT;
							fin_q <= 1'b1;
						end else if (oj_q + 1'b1 < nob) begin
							oj_q    <= oj_q + 1'b1;
							state_q <= ST_PT_FETCH;
						end else if (pi_nx < pcnt_q) begin
							pi_q    <= pi_nx;
							oj_q    <= '0;
							state_q <= ST_PT_FETCH;
						end else begin
							state_q <= ST_SEG_INIT;
						end
					end
					ST_SEG_INIT: begin
						pi_q   <= '0;
						oj_q   <= '0;
						fcnt_q <= '0;
						if (pcnt_q < PCNT_W'(2)) begin
							res_q <= CAUSE_NONE;
							fin_q <= 1'b1;
						end else if (nob != '0) begin
							state_q <= ST_SEG_FETCH;
						end else begin
							state_q <= ST_SELF_INIT;
						end
					end
					ST_SEG_FETCH: begin
						if (fcnt_q == nreads) begin
							state_q <= ST_SEG_MUL;
						end else begin
							fcnt_q <= fcnt_q + 1'b1;
						end
					end
					ST_SEG_MUL: begin
						if (mcnt_q == nprods) begin
							state_q <= ST_SEG_CHK;
						end else begin
							mcnt_q <= mcnt_q + 1'b1;
						end
					end
					ST_SEG_CHK: begin
						// start of segment inside, end inside, or vertex test
						ser_mc_q  <= {{SER_W{1'b0}}, SER_W'(acc_q[0])};
						ser_ml_q  <= SER_W'(c_seg);
						ser_nb_q  <= SER_W'(-acc_q[1]);
						ser_acc_q <= '0;
						ser_cnt_q <= '0;
						ser_ph_q  <= 1'b0;
						if (c_seg <= 0 || end_seg <= 0) begin
							res_q <= CAUSE_SEGMENT;
							fin_q <= 1'b1;
						end else if (acc_q[0] > 0 && acc_q[1] < 0 && -acc_q[1] < acc_q[0]) begin
							state_q <= ST_SER;
						end else begin
							state_q <= ST_SEG_NEXT;
						end
					end
					ST_SER: begin
						ser_mc_q  <= ser_mc_q << 1;
						ser_ml_q  <= ser_ml_q >> 1;
						ser_acc_q <= ser_sum;
						ser_cnt_q <= ser_cnt_q + 1'b1;
						if (32'(ser_cnt_q) == SER_W - 1) begin
							ser_cnt_q <= '0;
							if (!ser_ph_q) begin
								// a*c done, now bh squared
								ser_lhs_q <= ser_sum;
								ser_mc_q  <= {{SER_W{1'b0}}, ser_nb_q};
								ser_ml_q  <= ser_nb_q;
								ser_acc_q <= '0;
								ser_ph_q  <= 1'b1;
							end else begin
								state_q <= ST_SER_CHK;
							end
						end
					end
					ST_SER_CHK: begin
						if (ser_lhs_q <= ser_acc_q) begin
							res_q <= CAUSE_SEGMENT;
							fin_q <= 1'b1;
						end else begin
							state_q <= ST_SEG_NEXT;
						end
					end
					ST_SEG_NEXT: begin
						fcnt_q <= '0;
						if (oj_q + 1'b1 < nob) begin
							oj_q    <= oj_q + 1'b1;
							state_q <= ST_SEG_FETCH;
						end else if (pi_nx + 1'b1 < pcnt_q) begin
							pi_q    <= pi_nx;
							oj_q    <= '0;
							state_q <= ST_SEG_FETCH;
						end else begin
							state_q <= ST_SELF_INIT;
						end
					end
					ST_SELF_INIT: begin
						ci_q    <= '0;
						cj_q    <= CTR_W'(SELF_GAP);
						total_q <= total_nx;
						fcnt_q  <= '0;
						if (total_nx > CTR_W'(SELF_GAP)) begin
							state_q <= ST_SELF_FETCH;
						end else begin
							res_q <= CAUSE_NONE;
							fin_q <= 1'b1;
						end
					end
					ST_SELF_FETCH: begin
						if (fcnt_q == nreads) begin
							state_q <= ST_SELF_MUL;
						end else begin
							fcnt_q <= fcnt_q + 1'b1;
						end
					end
					ST_SELF_MUL: begin
						if (mcnt_q == nprods) begin
							state_q <= ST_SELF_CHK;
						end else begin
							mcnt_q <= mcnt_q + 1'b1;
						end
					end
					ST_SELF_CHK: begin
						fcnt_q <= '0;
						if (acc_q[0] < acc_q[1]) begin
							res_q <= CAUSE_SELF;
							fin_q <= 1'b1;
						end else if (cj_q + 1'b1 < total_q) begin
							cj_q    <= cj_q + 1'b1;
							state_q <= ST_SELF_FETCH;
						end else if (ci_nx + CTR_W'(SELF_GAP) < total_q) begin
							ci_q    <= ci_nx;
							cj_q    <= ci_nx + CTR_W'(SELF_GAP);
							state_q <= ST_SELF_FETCH;
						end else begin
							res_q <= CAUSE_NONE;
							fin_q <= 1'b1;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	`APCC_ASSERT_NXT(a_strobe_single, done_q, !done_q, "apcc_back: result strobe held")
	`APCC_ASSERT_NXT(a_pose_cleared, fin_q, pcnt_q == '0 && done_q, "apcc_back: pose not closed")
	`APCC_ASSERT_IMP(a_cause_range, done_q, cause_q <= CAUSE_SELF && collision_q == (cause_q != CAUSE_NONE),
		"apcc_back: bad verdict")

endmodule

`default_nettype wire

[design/arm_pose_collision_check_core.sv]
// ----------------------------------------------------------------------------
// arm_pose_collision_check_core
// obstacle table and arm pose collision verdict
// ----------------------------------------------------------------------------
// Items enter on start while busy is low: command 0 loads an obstacle into
// slot, command 1 adds a pose point; last on a point closes the pose.
// Registers are written on cfg_valid (cfg_ready is always high) at
// cfg_index 0 obstacle_count, 1 table height limit, 2 self_radius.
// Items pass through a two-entry queue to the checking engine, so busy only
// rises when the queue is full. A load or a plain point leaves the queue in the
// cycle after it is taken when the engine is idle. A closing point gives one
// result on done, one cycle wide, with collision and cause; the receiver
// cannot stall it.
// Verdict time is set by the single shared 19x19 multiplier and the serial
// vertex multiplier. After the table test it checks point-obstacle pairs,
// link-obstacle pairs (with the serial step when the closest approach lies
// inside the link) and self sphere pairs, stopping at the first hit.
// Reset clears the pose, the queue and the registers to their defaults; the
// obstacle table holds nothing meaningful until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arm_pose_collision_check_core #(
	parameter int MAX_OBSTACLES = 8,
	parameter int MAX_POINTS    = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             command,
	input  wire logic [apcc_pkg::SLOT_W-1:0]      slot,
	input  wire logic signed [15:0]               pos_x,
	input  wire logic signed [15:0]               pos_y,
	input  wire logic signed [15:0]               pos_z,
	input  wire logic [apcc_pkg::RAD_W-1:0]       radius,
	input  wire logic                             last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [apcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [apcc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                  done,
	output logic                                  collision,
	output logic [apcc_pkg::CAUSE_W-1:0]          cause
);
	import apcc_pkg::*;

	cfg_regs_t   cfg;
	queue_item_t push_item;
	queue_item_t head_item;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;

	// item intake and registers
	apcc_front #(
		.MAX_OBSTACLES(MAX_OBSTACLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.slot     (slot),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.radius   (radius),
		.last     (last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item),
		.cfg      (cfg)
	);

	// decoupling queue
	apcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (push_item),
		.full    (q_full),
		.pop     (q_pop),
		.item_out(head_item),
		.empty   (q_empty)
	);

	// checking engine
	apcc_back #(
		.MAX_OBSTACLES(MAX_OBSTACLES),
		.MAX_POINTS   (MAX_POINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.empty    (q_empty),
		.item     (head_item),
		.pop      (q_pop),
		.done     (done),
		.collision(collision),
		.cause    (cause)
	);

endmodule

`default_nettype wire

[dv/arm_pose_collision_check_core_test.sv]
// ----------------------------------------------------------------------------
// arm_pose_collision_check_core_test
// self-checking bench: directed table then random obstacle loads and poses,
// each pose verdict checked against the row's cause or an in-bench predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_pose_collision_check_core_test;
	import apcc_pkg::*;

	localparam int N_OBST      = 8;
	localparam int N_PTS       = 8;
	localparam int SETTLE      = 24;
	localparam int STALL_LIMIT = 40000;
	localparam int ITEM_GOAL   = 1300;

	typedef enum logic [1:0] {ROW_LOAD, ROW_POINT, ROW_REG} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [2:0]  slot;
		int          x, y, z, r;
		logic        last;
		bit          typed;
		logic [2:0]  cause;
	} stim_row_t;

	typedef struct {
		logic       collision;
		logic [2:0] cause;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic command = 1'b0;
	logic [SLOT_W-1:0] slot = '0;
	logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [RAD_W-1:0] radius = '0;
	logic last = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire busy, cfg_ready, done, collision;
	wire [CAUSE_W-1:0] cause;

	arm_pose_collision_check_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .radius(radius), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .collision(collision), .cause(cause)
	);

	always #5 clk = ~clk;

	// shadow state of the block
	vec_t        obst_c [N_OBST];
	logic [14:0] obst_r [N_OBST];
	vec_t        pose   [N_PTS];
	int          pose_len = 0;
	int          sh_count = 0;
	longint      sh_margin = -819;
	longint      sh_srad = 164;

	verdict_t pending_verdicts[$];
	int errors = 0;
	int items = 0;
	int stall = 0;
	bit burst = 0;

	// closed segment against closed ball, division free
	function automatic bit segment_touches(vec_t p1, vec_t p2, int k);
		longint wx, wy, wz, vx, vy, vz, a, bh, c;
		logic signed [127:0] lhs, rhs;
		wx = longint'(p1.x) - longint'(obst_c[k].x);
		wy = longint'(p1.y) - longint'(obst_c[k].y);
		wz = longint'(p1.z) - longint'(obst_c[k].z);
		vx = longint'(p2.x) - longint'(p1.x);
		vy = longint'(p2.y) - longint'(p1.y);
		vz = longint'(p2.z) - longint'(p1.z);
		a  = vx*vx + vy*vy + vz*vz;
		bh = vx*wx + vy*wy + vz*wz;
		c  = wx*wx + wy*wy + wz*wz - longint'(obst_r[k]) * longint'(obst_r[k]);
		if (c <= 0) return 1;
		if (a + 2*bh + c <= 0) return 1;
		if (a > 0 && bh < 0 && -bh < a) begin
			lhs = a;
			lhs = lhs * c;
			rhs = bh;
			rhs = rhs * rhs;
			return lhs <= rhs;
		end
		return 0;
	endfunction

	// link sphere centre k, scaled by three
	function automatic void sphere_centre(int k, output longint cx, output longint cy,
			output longint cz);
		int l, s;
		l = k / SPHERE_SLOTS;
		s = k % SPHERE_SLOTS;
		cx = longint'(pose[l].x) * (3 - s) + longint'(pose[l+1].x) * s;
		cy = longint'(pose[l].y) * (3 - s) + longint'(pose[l+1].y) * s;
		cz = longint'(pose[l].z) * (3 - s) + longint'(pose[l+1].z) * s;
	endfunction

	function automatic logic [2:0] pose_verdict();
		int n, nob, total;
		longint dx, dy, dz, lim, ax, ay, az, bx, by, bz;
		n = pose_len;
		nob = (sh_count > N_OBST) ? N_OBST : sh_count;
		if (n == 0) return CAUSE_NONE;
		if (longint'(pose[n-1].z) < sh_margin) return CAUSE_TABLE;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < nob; j++) begin
				dx = longint'(pose[i].x) - longint'(obst_c[j].x);
				dy = longint'(pose[i].y) - longint'(obst_c[j].y);
				dz = longint'(pose[i].z) - longint'(obst_c[j].z);
				if (dx*dx + dy*dy + dz*dz < longint'(obst_r[j]) * longint'(obst_r[j]))
					return CAUSE_POINT;
			end
		if (n < 2) return CAUSE_NONE;
		for (int i = 0; i + 1 < n; i++)
			for (int j = 0; j < nob; j++)
				if (segment_touches(pose[i], pose[i+1], j)) return CAUSE_SEGMENT;
		total = (n - 1) * SPHERE_SLOTS;
		lim = 2 * sh_srad * SPHERES_PER_LINK;
		lim = lim * lim;
		for (int i = 0; i < total; i++)
			for (int j = i + SELF_GAP; j < total; j++) begin
				sphere_centre(i, ax, ay, az);
				sphere_centre(j, bx, by, bz);
				dx = ax - bx; dy = ay - by; dz = az - bz;
				if (dx*dx + dy*dy + dz*dz < lim) return CAUSE_SELF;
			end
		return CAUSE_NONE;
	endfunction

	// advance the shadow state by one accepted item
	function automatic bit take_item(logic cmd, logic [2:0] sl, vec_t p, logic [14:0] r,
			logic lst, output logic [2:0] c);
		c = CAUSE_NONE;
		if (cmd == CMD_LOAD) begin
			obst_c[sl] = p;
			obst_r[sl] = r;
			return 0;
		end
		if (pose_len < N_PTS) begin
			pose[pose_len] = p;
			pose_len++;
		end
		if (!lst) return 0;
		c = pose_verdict();
		pose_len = 0;
		return 1;
	endfunction

	// drive one item and wait for it to be taken
	task automatic send_item(logic cmd, logic [2:0] sl, int x, int y, int z, int r,
			logic lst, bit typed = 0, logic [2:0] typed_cause = CAUSE_NONE);
		int gap;
		vec_t p;
		logic [2:0] c;
		verdict_t v;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		p.x = 16'(x); p.y = 16'(y); p.z = 16'(z);
		start <= 1'b1;
		command <= cmd; slot <= sl; radius <= 15'(r); last <= lst;
		pos_x <= p.x; pos_y <= p.y; pos_z <= p.z;
		do @(posedge clk); while (busy);
		if (take_item(cmd, sl, p, 15'(r), lst, c)) begin
			if (typed) c = typed_cause;
			v.collision = (c != CAUSE_NONE);
			v.cause = c;
			pending_verdicts = {pending_verdicts, v};
		end
		items++;
		@(negedge clk);
	endtask

	// let the block drain before touching registers
	task automatic wait_quiet();
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OBSTACLE_COUNT: sh_count = val & 15;
			CFG_HEIGHT_LIMIT:   sh_margin = longint'($signed(16'(val)));
			default:            sh_srad = val & 16'h3fff;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int near_coord();
		return ($urandom % 10 == 0) ? int'($signed(16'($urandom)))
			: $urandom_range(0, 8000) - 4000;
	endfunction

	// result checking
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected verdict collision=%0b cause=%0d", collision, cause);
			end else begin
				v = pending_verdicts.pop_front();
				if (collision !== v.collision || cause !== v.cause) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp collision=%0b cause=%0d got %0b %0d",
							v.collision, v.cause, collision, cause);
				end
			end
		end
	end

	// watchdog on cycles with nothing moving
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall <= 0;
		else stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("arm_pose_collision_check_core verification failed");
			$finish;
		end
	end

	stim_row_t rows[$];

	initial begin
		int npts, bx, by, bz, px, py, pz;
		int pick;
		rows = '{
			'{ROW_POINT, 0, 0, 0, -820, 0, 1, 1, CAUSE_TABLE},
			'{ROW_POINT, 0, 0, 0, -819, 0, 1, 1, CAUSE_NONE},
			'{ROW_POINT, 0, 32767, 32767, 32767, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, -32768, -32768, -32768, 0, 1, 1, CAUSE_TABLE},
			'{ROW_LOAD, 0, 0, 0, 0, 100, 1, 0, CAUSE_NONE},
			'{ROW_LOAD, 1, 1000, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 2, -32768, -32768, 32767, 5, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 3, -32768, 32767, -32768, 5, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 4, 32767, -32768, -32768, 5, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 5, -32768, -32768, -32768, 0, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 6, 30000, -30000, 30000, 20, 0, 0, CAUSE_NONE},
			'{ROW_LOAD, 7, 32767, 32767, 32767, 32767, 0, 0, CAUSE_NONE},
			'{ROW_REG, CFG_OBSTACLE_COUNT, 2, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 50, 0, 0, 0, 1, 1, CAUSE_POINT},
			'{ROW_POINT, 0, -200, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 200, 0, 0, 0, 1, 1, CAUSE_SEGMENT},
			'{ROW_POINT, 0, 500, 300, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 1000, 0, 0, 0, 1, 1, CAUSE_SEGMENT},
			'{ROW_REG, CFG_SELF_RADIUS, 16383, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 2000, 2000, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 3000, 2000, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_POINT, 0, 4000, 2000, 0, 0, 1, 1, CAUSE_SELF},
			'{ROW_REG, CFG_OBSTACLE_COUNT, 15, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_REG, CFG_SELF_RADIUS, 0, 0, 0, 0, 0, 0, CAUSE_NONE},
			'{ROW_REG, CFG_HEIGHT_LIMIT, -32768, 0, 0, 0, 0, 0, CAUSE_NONE}
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (rows[i]) begin
			if (rows[i].op == ROW_REG) begin
				wait_quiet();
				write_reg(rows[i].slot[CFG_IDX_W-1:0], rows[i].x);
			end else begin
				send_item(rows[i].op == ROW_LOAD ? CMD_LOAD : CMD_POINT, rows[i].slot,
					rows[i].x, rows[i].y, rows[i].z, rows[i].r, rows[i].last,
					rows[i].typed, rows[i].cause);
			end
		end
		// overlong pose against the clamped obstacle count
		for (int k = 0; k < 10; k++)
			send_item(CMD_POINT, 3'($urandom), -20000 + 3000*k, 100*k, 500, 0, k == 9);

		// random phases
		while (items < ITEM_GOAL) begin
			wait_quiet();
			pick = $urandom_range(0, 5);
			write_reg(CFG_OBSTACLE_COUNT, pick == 0 ? 0 : pick == 1 ? 8 : pick == 2 ? 15
				: $urandom_range(0, 15));
			pick = $urandom_range(0, 7);
			write_reg(CFG_HEIGHT_LIMIT, pick == 0 ? -32768 : pick == 1 ? 32767
				: pick == 2 ? int'($signed(16'($urandom))) : $urandom_range(0, 4000) - 3000);
			pick = $urandom_range(0, 7);
			write_reg(CFG_SELF_RADIUS, pick == 0 ? 0 : pick == 1 ? 16383
				: pick == 2 ? $urandom_range(0, 16383) : $urandom_range(0, 500));
			for (int done_items = items; items - done_items < 65; ) begin
				burst = ($urandom_range(0, 4) == 0);
				// obstacle reload near the working volume
				if ($urandom_range(0, 2) == 0)
					send_item(CMD_LOAD, 3'($urandom), near_coord(), near_coord(), near_coord(),
						($urandom % 8 == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 2500),
						1'($urandom));
				// stray item with every field random
				if ($urandom_range(0, 9) == 0)
					send_item(1'($urandom), 3'($urandom), int'($signed(16'($urandom))),
						int'($signed(16'($urandom))), int'($signed(16'($urandom))),
						int'(15'($urandom)), 1'($urandom));
				// well-formed pose of short links
				npts = ($urandom % 10 == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
				bx = near_coord(); by = near_coord(); bz = near_coord();
				for (int k = 0; k < npts; k++) begin
					px = bx + $urandom_range(0, 3000) - 1500;
					py = by + $urandom_range(0, 3000) - 1500;
					pz = bz + $urandom_range(0, 3000) - 1500;
					bx = px; by = py; bz = pz;
					send_item(CMD_POINT, 3'($urandom), px, py, pz, int'(15'($urandom)),
						k == npts - 1);
				end
			end
			burst = 0;
		end

		// drain
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("arm_pose_collision_check_core verification clean");
		else
			$display("arm_pose_collision_check_core verification failed");
		$finish;
	end

endmodule
